// ===== rtl/rkg_pkg.sv =====
// ----------------------------------------------------------------------------
// rkg_pkg
// Shared types, constants and the nonlinear filter of the keystream generator.
// ----------------------------------------------------------------------------
package rkg_pkg;

    // Field and register widths.
    localparam int STATE_W = 48;
    localparam int KEY_W   = 48;
    localparam int SER_W   = 32;
    localparam int IV_W    = 32;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 1;

    // Rounds done by the row of cells in one cycle, and initialisation passes.
    localparam int CELLS       = 8;
    localparam int INIT_ROUNDS = 32;
    localparam int INIT_PASSES = INIT_ROUNDS / CELLS;
    localparam int CNT_W       = $clog2(INIT_PASSES);

    // Width of the IV and key bits still waiting after the first pass.
    localparam int REST_W = INIT_ROUNDS - CELLS;

    // Low key bits loaded into the register above the serial.
    localparam int KEY_LO_W = STATE_W - SER_W;

    // Function codes of an input item.
    localparam logic FUNC_INIT = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SECRET_KEY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_SERIAL = 1'b1;

    // Filter tables.
    localparam logic [15:0] TAB4A = 16'h2C79;
    localparam logic [15:0] TAB4B = 16'h6671;
    localparam logic [31:0] TAB5  = 32'h7907_287B;

    // Feedback taps 0,2,3,6,7,8,16,22,23,26,30,41,42,43,46,47.
    localparam logic [STATE_W-1:0] LFSR_TAPS = 48'hCE00_44C1_01CD;

    typedef logic [STATE_W-1:0] t_state;

    // Twenty-input filter: five small tables feed one five-input table.
    function automatic logic filter20(input t_state v);
        logic [4:0] sel;
        sel[0] = TAB4A[{v[5],  v[4],  v[2],  v[1]}];
        sel[1] = TAB4B[{v[14], v[13], v[11], v[7]}];
        sel[2] = TAB4B[{v[25], v[22], v[20], v[16]}];
        sel[3] = TAB4B[{v[32], v[30], v[28], v[27]}];
        sel[4] = TAB4A[{v[45], v[43], v[42], v[33]}];
        return TAB5[sel];
    endfunction

endpackage

// ===== rtl/rkg_in_if.sv =====
// ----------------------------------------------------------------------------
// rkg_in_if
// Request channel: function code and initialisation vector of one item.
// ----------------------------------------------------------------------------
interface rkg_in_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [rkg_pkg::IV_W-1:0]  init_vector;

    modport source (output valid, output func, output init_vector, input ready);
    modport sink   (input valid, input func, input init_vector, output ready);
endinterface

// ===== rtl/rkg_out_if.sv =====
// ----------------------------------------------------------------------------
// rkg_out_if
// Result channel: one keystream byte per byte item.
// ----------------------------------------------------------------------------
interface rkg_out_if;
    logic                        valid;
    logic                        ready;
    logic [rkg_pkg::BYTE_W-1:0]  keystream_byte;

    modport source (output valid, output keystream_byte, input ready);
    modport sink   (input valid, input keystream_byte, output ready);
endinterface

// ===== rtl/rkg_round_cell.sv =====
// ----------------------------------------------------------------------------
// rkg_round_cell
// One cipher round: an initialisation round or a feedback round with filter.
// ----------------------------------------------------------------------------
module rkg_round_cell (
    input  rkg_pkg::t_state i_state,
    input  logic            i_init,
    input  logic            i_iv_bit,
    input  logic            i_key_bit,
    output rkg_pkg::t_state o_state,
    output logic            o_bit
);

    rkg_pkg::t_state shifted;
    logic            fb;
    logic            ins;

    // Shift right; bit 47 of the shifted word is empty until the insert.
    assign shifted = {1'b0, i_state[rkg_pkg::STATE_W-1:1]};

    // Linear feedback over the tap positions of the incoming state.
    assign fb = ^(i_state & rkg_pkg::LFSR_TAPS);

    // Initialisation inserts the filter of the shifted word mixed with IV and key.
    assign ins = i_init ? (rkg_pkg::filter20(shifted) ^ i_iv_bit ^ i_key_bit) : fb;

    assign o_state = {ins, shifted[rkg_pkg::STATE_W-2:0]};

    // Keystream bit is the filter of the new state.
    assign o_bit = rkg_pkg::filter20(o_state);

endmodule

// ===== rtl/rfid_keystream_generator.sv =====
// ----------------------------------------------------------------------------
// rfid_keystream_generator
// Stream cipher keystream generator built from a row of eight round cells.
// ----------------------------------------------------------------------------
// Usage:
//   Write secret_key (index 0) and tag_serial (index 1) on the configuration
//   port while the block is idle. Send an item with func = 0 and the IV to
//   initialise the cipher register; it gives no result. Each item with
//   func = 1 then gives one keystream byte, the first generated bit in bit 7.
// Timing:
//   The row of eight cells runs eight rounds per cycle. A byte item's result
//   is registered and sits in the output register on the next cycle, so
//   bytes flow at one per cycle while the receiver keeps ready high. An
//   initialise item needs 32 rounds, that is four passes through the row,
//   and holds ready low after its acceptance until the remaining passes end.
// Reset:
//   Clears the cipher register, the pass counter, both configuration registers
//   and the output valid flag.
// Stall:
//   While a result waits and the receiver holds ready low, the result holds
//   and no new item is taken; when the result is taken a new item can be
//   accepted in the same cycle.
// ----------------------------------------------------------------------------
module rfid_keystream_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rkg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rkg_pkg::KEY_W-1:0]        i_cfg_data,
    rkg_in_if.sink                           i_req,
    rkg_out_if.source                        o_rsp
);

    localparam int CELLS = rkg_pkg::CELLS;

    logic [rkg_pkg::KEY_W-1:0]   r_secret_key;
    logic [rkg_pkg::SER_W-1:0]   r_tag_serial;
    rkg_pkg::t_state             r_state;
    logic [rkg_pkg::CNT_W-1:0]   r_cnt;
    logic [rkg_pkg::REST_W-1:0]  r_iv;
    logic [rkg_pkg::REST_W-1:0]  r_kx;
    logic                        r_out_valid;
    logic [rkg_pkg::BYTE_W-1:0]  r_out_byte;

    logic                        busy;
    logic                        accept;
    logic                        chain_init;
    rkg_pkg::t_state             chain_in;
    logic [CELLS-1:0]            iv_bits;
    logic [CELLS-1:0]            key_bits;
    rkg_pkg::t_state             stage [CELLS+1];
    logic [CELLS-1:0]            ks_bits;
    logic [rkg_pkg::BYTE_W-1:0]  ks_byte;

    // Handshake: no item while initialisation passes run or a result is stuck.
    assign busy        = (r_cnt != '0);
    assign i_req.ready = !busy && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    // Inputs of the cell row: a fresh load, a running initialisation or a byte.
    always_comb begin
        if (busy) begin
            chain_init = 1'b1;
            chain_in   = r_state;
            iv_bits    = r_iv[CELLS-1:0];
            key_bits   = r_kx[CELLS-1:0];
        end else if (i_req.func == rkg_pkg::FUNC_INIT) begin
            chain_init = 1'b1;
            chain_in   = {r_secret_key[rkg_pkg::KEY_LO_W-1:0], r_tag_serial};
            iv_bits    = i_req.init_vector[CELLS-1:0];
            key_bits   = r_secret_key[rkg_pkg::KEY_LO_W +: CELLS];
        end else begin
            chain_init = 1'b0;
            chain_in   = r_state;
            iv_bits    = i_req.init_vector[CELLS-1:0];
            key_bits   = r_secret_key[rkg_pkg::KEY_LO_W +: CELLS];
        end
    end

    // Row of round cells, each handing its state to the next.
    assign stage[0] = chain_in;
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        rkg_round_cell u_cell (
            .i_state   (stage[g]),
            .i_init    (chain_init),
            .i_iv_bit  (iv_bits[g]),
            .i_key_bit (key_bits[g]),
            .o_state   (stage[g+1]),
            .o_bit     (ks_bits[g])
        );
    end

    // First cell's bit goes to the most significant position.
    always_comb begin
        for (int k = 0; k < CELLS; k++) begin
            ks_byte[CELLS-1-k] = ks_bits[k];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secret_key <= '0;
            r_tag_serial <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rkg_pkg::REG_SECRET_KEY: r_secret_key <= i_cfg_data;
                rkg_pkg::REG_TAG_SERIAL: r_tag_serial <= i_cfg_data[rkg_pkg::SER_W-1:0];
            endcase
        end
    end

    // Cipher register and initialisation sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= '0;
        end else if (busy) begin
            r_state <= stage[CELLS];
            r_cnt   <= r_cnt - rkg_pkg::CNT_W'(1);
        end else if (accept) begin
            r_state <= stage[CELLS];
            if (i_req.func == rkg_pkg::FUNC_INIT) begin
                r_cnt <= rkg_pkg::CNT_W'(rkg_pkg::INIT_PASSES - 1);
            end
        end
    end

    // Remaining IV and key bits, one byte consumed per pass.
    always_ff @(posedge i_clk) begin
        if (busy) begin
            r_iv <= {{CELLS{1'b0}}, r_iv[rkg_pkg::REST_W-1:CELLS]};
            r_kx <= {{CELLS{1'b0}}, r_kx[rkg_pkg::REST_W-1:CELLS]};
        end else if (accept) begin
            r_iv <= i_req.init_vector[rkg_pkg::IV_W-1:CELLS];
            r_kx <= r_secret_key[rkg_pkg::KEY_W-1:rkg_pkg::KEY_LO_W+CELLS];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_req.func == rkg_pkg::FUNC_BYTE) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.func == rkg_pkg::FUNC_BYTE) begin
            r_out_byte <= ks_byte;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.keystream_byte = r_out_byte;

    // No item is taken while initialisation passes are still running.
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !i_req.ready)
        else $error("item accepted during initialisation");

    // A byte item always leaves a result in the output register.
    a_byte_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.func == rkg_pkg::FUNC_BYTE) |=> r_out_valid)
        else $error("byte item gave no result");

    // An initialise item starts the remaining passes.
    a_init_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.func == rkg_pkg::FUNC_INIT)
            |=> (r_cnt == rkg_pkg::CNT_W'(rkg_pkg::INIT_PASSES - 1)))
        else $error("initialisation pass count wrong");

    // A stalled result keeps its value.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out_byte)))
        else $error("stalled result changed");

endmodule
